FILE: hw/rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// shared types and constants of the linear interpolation resampler
// ----------------------------------------------------------------------------
package lirs_pkg;

    // sample and phase formats
    localparam int SAMPLE_BITS     = 24;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int PHASE_BITS      = 28;
    localparam int RATIO_BITS      = 28;
    localparam int CFG_DATA_BITS   = 28;
    localparam int PRIME_BITS      = 2;

    // bound on device frames produced by one source frame
    localparam int MAX_OUTPUTS = 64;
    localparam int COUNT_BITS  = $clog2(MAX_OUTPUTS);

    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(64'd1 << PHASE_FRAC_BITS);
    localparam logic [RATIO_BITS-1:0] RATIO_MIN =
        RATIO_BITS'(((64'd1 << PHASE_FRAC_BITS) + 64'(MAX_OUTPUTS) - 64'd1) / 64'(MAX_OUTPUTS));
    localparam logic [RATIO_BITS-1:0] RATIO_MAX = RATIO_BITS'((64'd1 << PHASE_FRAC_BITS) * 64'd8);
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(64'd1 << PHASE_FRAC_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(MAX_OUTPUTS - 1);

    // priming levels
    localparam logic [PRIME_BITS-1:0] PRIME_NONE = 2'd0;
    localparam logic [PRIME_BITS-1:0] PRIME_PREV = 2'd1;
    localparam logic [PRIME_BITS-1:0] PRIME_BOTH = 2'd2;

    // configuration register indexes
    localparam logic CFG_RATE_RATIO = 1'b0;
    localparam logic CFG_BYPASS     = 1'b1;

    typedef enum logic {
        OP_FRAME   = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_ADD_R,
        ST_EMIT
    } t_state;

endpackage

FILE: hw/rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// stereo linear interpolation sample rate converter with one shared multiplier
// ----------------------------------------------------------------------------
// A source frame is taken only while the block is idle. Restart items, frames
// that only prime the history and frames that land past the next pull leave
// the block idle. In bypass the frame comes back in the cycle after the
// transfer. In interpolating mode every device frame is built in order as left
// product, right product with left sum, and right sum, both products on the
// single shared multiplier, then goes out through its output transfer; an item
// producing n device frames holds the block until they are all out, with n at
// most 64. Each output is prev + floor(phase * (next - prev)) per channel,
// phase advancing by the saturated ratio after each output until it reaches
// one or hits the output bound. A final frame drains the block until a restart.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // source channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_operation,
    input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] i_in_right,
    input  logic                                  i_final_frame,
    // device channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [lirs_pkg::SAMPLE_BITS-1:0] o_out_left,
    output logic signed [lirs_pkg::SAMPLE_BITS-1:0] o_out_right,
    output logic                                  o_last,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [lirs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int SB = lirs_pkg::SAMPLE_BITS;
    localparam int FB = lirs_pkg::PHASE_FRAC_BITS;
    localparam int PB = lirs_pkg::PHASE_BITS;

    // configuration
    logic [lirs_pkg::RATIO_BITS-1:0] r_ratio;
    logic                            r_bypass;

    // sequencer and history
    lirs_pkg::t_state r_state, n_state;
    logic signed [SB-1:0] r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic signed [SB-1:0] r_next_l, n_next_l, r_next_r, n_next_r;
    logic [PB-1:0] r_phase, n_phase;
    logic [lirs_pkg::PRIME_BITS-1:0] r_prime, n_prime;
    logic r_drained, n_drained;
    logic [lirs_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic r_pass, n_pass;

    // shared multiplier result, already shifted down by the phase fraction
    logic [SB-1:0] r_prod, n_prod;

    // output register
    logic signed [SB-1:0] r_out_l, n_out_l, r_out_r, n_out_r;
    logic r_last, n_last;

    logic signed [SB:0]      diff_l, diff_r, mul_d;
    logic signed [2*SB+1:0]  mul_p;
    logic [PB-1:0]           ratio_used;
    logic [PB-1:0]           phase_sum;
    logic [PB-1:0]           phase_wrap;
    logic                    phase_ge_one;
    logic                    sum_ge_one;

    // ratio saturated to the supported range
    always_comb begin
        if (r_ratio < lirs_pkg::RATIO_MIN) begin
            ratio_used = lirs_pkg::RATIO_MIN;
        end else if (r_ratio > lirs_pkg::RATIO_MAX) begin
            ratio_used = lirs_pkg::RATIO_MAX;
        end else begin
            ratio_used = r_ratio;
        end
    end

    assign phase_sum    = r_phase + ratio_used;
    assign phase_ge_one = (r_phase >= lirs_pkg::PHASE_ONE);
    assign sum_ge_one   = (phase_sum >= lirs_pkg::PHASE_ONE);
    // phase after a pull: drop one whole frame, or restart at zero
    assign phase_wrap   = phase_ge_one ? (r_phase - lirs_pkg::PHASE_ONE) : '0;

    assign diff_l = {r_next_l[SB-1], r_next_l} - {r_prev_l[SB-1], r_prev_l};
    assign diff_r = {r_next_r[SB-1], r_next_r} - {r_prev_r[SB-1], r_prev_r};

    // the one multiplier: phase fraction times left or right difference
    assign mul_d = (r_state == lirs_pkg::ST_MUL_R) ? diff_r : diff_l;
    assign mul_p = (2*SB+2)'($signed({1'b0, r_phase[FB-1:0]})) * (2*SB+2)'(mul_d);

    always_comb begin
        n_state   = r_state;
        n_prev_l  = r_prev_l;
        n_prev_r  = r_prev_r;
        n_next_l  = r_next_l;
        n_next_r  = r_next_r;
        n_phase   = r_phase;
        n_prime   = r_prime;
        n_drained = r_drained;
        n_count   = r_count;
        n_pass    = r_pass;
        n_prod    = r_prod;
        n_out_l   = r_out_l;
        n_out_r   = r_out_r;
        n_last    = r_last;

        unique case (r_state)
            lirs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_operation == lirs_pkg::OP_RESTART) begin
                        // clear priming, phase and drained; samples stay
                        n_prime   = lirs_pkg::PRIME_NONE;
                        n_phase   = '0;
                        n_drained = 1'b0;
                    end else if (!r_drained) begin
                        // a final frame drains the block once its outputs are out
                        if (i_final_frame) begin
                            n_drained = 1'b1;
                        end
                        if (r_bypass) begin
                            n_out_l = i_in_left;
                            n_out_r = i_in_right;
                            n_last  = 1'b1;
                            n_pass  = 1'b1;
                            n_state = lirs_pkg::ST_EMIT;
                        end else if (r_prime == lirs_pkg::PRIME_NONE) begin
                            n_prev_l = i_in_left;
                            n_prev_r = i_in_right;
                            n_phase  = '0;
                            if (!i_final_frame) begin
                                n_prime = lirs_pkg::PRIME_PREV;
                            end else begin
                                // lone final frame interpolates against itself
                                n_next_l = i_in_left;
                                n_next_r = i_in_right;
                                n_prime  = lirs_pkg::PRIME_BOTH;
                                n_count  = '0;
                                n_pass   = 1'b0;
                                n_state  = lirs_pkg::ST_MUL_L;
                            end
                        end else if (r_prime == lirs_pkg::PRIME_PREV) begin
                            n_next_l = i_in_left;
                            n_next_r = i_in_right;
                            n_phase  = '0;
                            n_prime  = lirs_pkg::PRIME_BOTH;
                            n_count  = '0;
                            n_pass   = 1'b0;
                            n_state  = lirs_pkg::ST_MUL_L;
                        end else begin
                            // running: shift history and pull one source frame
                            n_prev_l = r_next_l;
                            n_prev_r = r_next_r;
                            n_next_l = i_in_left;
                            n_next_r = i_in_right;
                            n_phase  = phase_wrap;
                            if (phase_wrap < lirs_pkg::PHASE_ONE) begin
                                n_count = '0;
                                n_pass  = 1'b0;
                                n_state = lirs_pkg::ST_MUL_L;
                            end
                        end
                    end
                end
            end
            lirs_pkg::ST_MUL_L: begin
                n_prod  = mul_p[SB+FB-1:FB];
                n_state = lirs_pkg::ST_MUL_R;
            end
            lirs_pkg::ST_MUL_R: begin
                n_out_l = r_prev_l + $signed(r_prod);
                n_prod  = mul_p[SB+FB-1:FB];
                n_state = lirs_pkg::ST_ADD_R;
            end
            lirs_pkg::ST_ADD_R: begin
                n_out_r = r_prev_r + $signed(r_prod);
                // last when the phase reaches a pull or the output bound is hit
                n_last  = sum_ge_one || (r_count == lirs_pkg::COUNT_LAST);
                n_state = lirs_pkg::ST_EMIT;
            end
            lirs_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    if (r_pass) begin
                        n_state = lirs_pkg::ST_IDLE;
                    end else begin
                        n_phase = phase_sum;
                        if (r_last) begin
                            n_state = lirs_pkg::ST_IDLE;
                        end else begin
                            n_count = r_count + lirs_pkg::COUNT_BITS'(1);
                            n_state = lirs_pkg::ST_MUL_L;
                        end
                    end
                end
            end
            default: begin
                n_state = lirs_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= lirs_pkg::RATIO_RESET;
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lirs_pkg::CFG_RATE_RATIO: r_ratio  <= i_cfg_data;
                lirs_pkg::CFG_BYPASS:     r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lirs_pkg::ST_IDLE;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_next_l  <= '0;
            r_next_r  <= '0;
            r_phase   <= '0;
            r_prime   <= lirs_pkg::PRIME_NONE;
            r_drained <= 1'b0;
            r_count   <= '0;
            r_pass    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev_l  <= n_prev_l;
            r_prev_r  <= n_prev_r;
            r_next_l  <= n_next_l;
            r_next_r  <= n_next_r;
            r_phase   <= n_phase;
            r_prime   <= n_prime;
            r_drained <= n_drained;
            r_count   <= n_count;
            r_pass    <= n_pass;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != lirs_pkg::ST_IDLE);
    assign o_valid     = (r_state == lirs_pkg::ST_EMIT);
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_last      = r_last;

    // a pending output always holds off the source side
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("output pending while input not stalled");

    // interpolated outputs only use a phase below one
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lirs_pkg::ST_MUL_L) |-> (r_phase < lirs_pkg::PHASE_ONE))
        else $error("interpolating with phase at or above one");

    // the output bound always closes the run
    a_bound_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_pass && r_count == lirs_pkg::COUNT_LAST) |-> r_last)
        else $error("run exceeded the per-frame output bound");

    // a final source frame leaves the block drained
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation == lirs_pkg::OP_FRAME && i_final_frame)
        |=> r_drained)
        else $error("final frame did not drain the block");

endmodule
